@@ sv/mseg_pkg.sv @@
// ----------------------------------------------------------------------------
// mseg_pkg
// Shared types, constants and trig table for the multisine excitation
// generator.
// ----------------------------------------------------------------------------
package mseg_pkg;

  localparam int MAX_HARMONICS   = 16;
  localparam int MAX_AXES        = 8;
  localparam int TRIG_TABLE_BITS = 10;

  localparam int RESULT_CAP  = 8;
  localparam int AXES_CAP    = (MAX_AXES < RESULT_CAP) ? MAX_AXES : RESULT_CAP;
  localparam int COEFF_DEPTH = MAX_HARMONICS * MAX_AXES;
  localparam int CADDR_W     = (COEFF_DEPTH > 1) ? $clog2(COEFF_DEPTH) : 1;
  localparam int H_W         = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int HN_W        = $clog2(MAX_HARMONICS + 1);
  localparam int K_W         = (AXES_CAP > 1) ? $clog2(AXES_CAP) : 1;
  localparam int QW_BITS     = TRIG_TABLE_BITS - 2;
  localparam int QUARTER     = 1 << QW_BITS;

  localparam int COEFF_W = 24;
  localparam int ACC_W   = 48;
  localparam int PADDR_W = 6;

  localparam logic [16:0] ENV_ONE = 17'd65536;
  localparam longint PI_HALF_Q30  = 64'd1686629713;

  // register indexes on the configuration port
  localparam logic [2:0] REG_DURATION = 3'd0;
  localparam logic [2:0] REG_RAMP     = 3'd1;
  localparam logic [2:0] REG_RECIP    = 3'd2;
  localparam logic [2:0] REG_HARM     = 3'd3;
  localparam logic [2:0] REG_AXES     = 3'd4;
  localparam logic [2:0] REG_KIND     = 3'd5;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_STOP    = 3'd1,
    ACT_RESTART = 3'd2,
    ACT_STEP    = 3'd3,
    ACT_SINE    = 3'd4,
    ACT_COSINE  = 3'd5
  } action_e;

  typedef struct packed {
    logic [31:0] duration;
    logic [30:0] ramp;
    logic [32:0] recip;
    logic [4:0]  harm;
    logic [3:0]  axes;
    logic [1:0]  kind;
  } cfg_t;

  typedef logic [15:0] qw_t [QUARTER+1];

  // quarter wave from a truncated taylor series in q30, scaled to q1.15
  function automatic qw_t build_qw();
    qw_t         tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    for (int i = 0; i <= QUARTER; i++) begin
      x    = (PI_HALF_Q30 * i) / QUARTER;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = sum - longint'(term);
        else            sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      tab[i] = 16'(((64'(sum) * 64'd32767) + (64'd1 << 29)) >> 30);
    end
    return tab;
  endfunction

  localparam qw_t QW = build_qw();

  // full-turn sine by quadrant symmetry
  function automatic logic signed [15:0] trig_sine(input logic [TRIG_TABLE_BITS-1:0] idx);
    logic [1:0]         quad;
    logic [QW_BITS-1:0] r;
    logic [QW_BITS:0]   mr;
    quad = idx[TRIG_TABLE_BITS-1 -: 2];
    r    = idx[QW_BITS-1:0];
    mr   = (QW_BITS+1)'(QUARTER) - {1'b0, r};
    case (quad)
      2'd0:    trig_sine = $signed(QW[r]);
      2'd1:    trig_sine = $signed(QW[mr]);
      2'd2:    trig_sine = -$signed(QW[r]);
      default: trig_sine = -$signed(QW[mr]);
    endcase
  endfunction

endpackage

@@ sv/mseg_ram.sv @@
// ----------------------------------------------------------------------------
// mseg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mseg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ sv/mseg_cfg.sv @@
// ----------------------------------------------------------------------------
// mseg_cfg
// APB-style configuration registers of the multisine generator.
// ----------------------------------------------------------------------------
module mseg_cfg
  import mseg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t       cfg_q;
  logic [2:0] ridx;
  logic       wr;

  assign ridx   = paddr[PADDR_W-1:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duration <= 32'd1000;
      cfg_q.ramp     <= 31'd100;
      cfg_q.recip    <= 33'd42949673;
      cfg_q.harm     <= 5'd1;
      cfg_q.axes     <= 4'd1;
      cfg_q.kind     <= 2'd0;
    end else if (wr) begin
      case (ridx)
        REG_DURATION: cfg_q.duration <= pwdata[31:0];
        REG_RAMP:     cfg_q.ramp     <= pwdata[30:0];
        REG_RECIP:    cfg_q.recip    <= pwdata[32:0];
        REG_HARM:     cfg_q.harm     <= pwdata[4:0];
        REG_AXES:     cfg_q.axes     <= pwdata[3:0];
        REG_KIND:     cfg_q.kind     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (ridx)
      REG_DURATION: prdata = 64'(cfg_q.duration);
      REG_RAMP:     prdata = 64'(cfg_q.ramp);
      REG_RECIP:    prdata = 64'(cfg_q.recip);
      REG_HARM:     prdata = 64'(cfg_q.harm);
      REG_AXES:     prdata = 64'(cfg_q.axes);
      REG_KIND:     prdata = 64'(cfg_q.kind);
      default:      prdata = 64'd0;
    endcase
  end

endmodule

@@ sv/mseg_env.sv @@
// ----------------------------------------------------------------------------
// mseg_env
// Five-stage smoothstep envelope unit, 3r^2-2r^3 in q1.16.
// ----------------------------------------------------------------------------
module mseg_env
  import mseg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] t_i,
  input  cfg_t        cfg_i,
  output logic [16:0] env_o,
  output logic        done_o
);

  logic [4:0]  vld_q;
  logic [3:0]  one_q;
  logic [31:0] n_q;
  logic [16:0] r16_q, r16b_q, r2_q, r2b_q, r3_q;
  logic [16:0] env_q;
  logic [31:0] half;
  logic [31:0] ramp_eff;
  logic [31:0] n_d;
  logic        one_d;
  logic [64:0] rp;
  logic [32:0] rsat;
  logic [33:0] sq;
  logic [33:0] cu;
  logic signed [19:0] e;

  // region tests with the ramp clamped to half the duration
  assign half     = cfg_i.duration >> 1;
  assign ramp_eff = ({1'b0, cfg_i.ramp} > half) ? half : {1'b0, cfg_i.ramp};

  always_comb begin
    n_d   = 32'd0;
    one_d = 1'b0;
    if (t_i < ramp_eff) n_d = t_i;
    else if (t_i > cfg_i.duration - ramp_eff) n_d = cfg_i.duration - t_i;
    else one_d = 1'b1;
  end

  // ramp position, square, cube, blend
  assign rp   = 65'(n_q) * 65'(cfg_i.recip);
  assign rsat = (rp > 65'h1_0000_0000) ? 33'h1_0000_0000 : rp[32:0];
  assign sq   = 34'(r16_q) * 34'(r16_q);
  assign cu   = 34'(r2_q) * 34'(r16b_q);
  assign e    = 20'sd3 * $signed({3'b0, r2b_q}) - 20'sd2 * $signed({3'b0, r3_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[3:0], start_i};
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    one_q  <= {one_q[2:0], one_d};
    r16_q  <= rsat[32:16];
    r2_q   <= sq[32:16];
    r16b_q <= r16_q;
    r3_q   <= cu[32:16];
    r2b_q  <= r2_q;
    if (one_q[3])                 env_q <= ENV_ONE;
    else if (e < 0)               env_q <= 17'd0;
    else if (e > $signed({3'b0, ENV_ONE})) env_q <= ENV_ONE;
    else                          env_q <= e[16:0];
  end

  assign env_o  = env_q;
  assign done_o = vld_q[4];

endmodule

@@ sv/multisine_excitation_generator.sv @@
// ----------------------------------------------------------------------------
// multisine_excitation_generator
// Multisine drive generator with smoothstep start and stop taper.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      in_valid_i / in_stall_o  action, harmonic/axis index,
//                                               phase_step, coefficient
//  out      output     out_valid_o / out_stall_i axis, kind, drive_value,
//                                               last_axis, finished
//  cfg      input      psel/penable/pwrite      six registers, 64-bit data
//
//  a tick is accepted, waits for the envelope, then per axis runs the harmonics
//  through the one shared coefficient multiply-accumulate over the coefficient
//  memories; writes complete in the accepting cycle, and stop, restart and a
//  tick past the duration emit one zero output per axis after the accepting one.
//  reset is asynchronous; coefficient memories read zero until written.
//  a stalled output holds the sequencer; input is taken only when idle.
// ----------------------------------------------------------------------------
module multisine_excitation_generator
  import mseg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         action_i,
  input  logic [3:0]         harmonic_index_i,
  input  logic [2:0]         axis_index_i,
  input  logic [31:0]        phase_step_i,
  input  logic signed [23:0] coefficient_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         axis_o,
  output logic [1:0]         kind_o,
  output logic signed [31:0] drive_value_o,
  output logic               last_axis_o,
  output logic               finished_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_ENV   = 7'b0000010,
    ST_MAC   = 7'b0000100,
    ST_DRAIN = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_OUT   = 7'b0100000,
    ST_ZERO  = 7'b1000000
  } state_e;

  cfg_t   cfg;
  state_e state_q, state_d;

  logic [31:0] tick_q, tick_d;
  logic        run_q, run_d;
  logic        fin_q, fin_d;
  logic [31:0] step_q  [MAX_HARMONICS];
  logic [31:0] phase_q [MAX_HARMONICS];
  logic [COEFF_DEPTH-1:0] sin_vld_q, cos_vld_q;

  logic [H_W-1:0] i_q, i_d;
  logic [K_W-1:0] k_q, k_d;
  logic           s1_q, s1_d, s2_q;
  logic           sv_q, cv_q;
  logic signed [15:0] sin_t_q, cos_t_q;
  logic signed [39:0] ps_q, pc_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    acc_clr;
  logic signed [65:0]      prod_q;
  logic signed [65:0]      sh;
  logic signed [31:0]      sat;

  logic                 accept;
  logic                 env_start, env_done;
  logic [16:0]          env;
  logic [31:0]          t_next;
  logic [HN_W-1:0]      nh;
  logic [3:0]           na;
  logic [CADDR_W-1:0]   raddr, waddr;
  logic [COEFF_W-1:0]   sin_rd, cos_rd;
  logic signed [23:0]   sin_c, cos_c;
  logic                 we_sin, we_cos;
  logic                 step_we, phase_adv, phase_clr;
  logic [TRIG_TABLE_BITS-1:0] tidx;
  logic                 last_k, last_i, slot_free, load;
  logic signed [31:0]   val_d;
  logic                 fin_out_d;

  mseg_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  mseg_env u_env (
    .clk_i, .rst_ni, .start_i(env_start), .t_i(tick_q), .cfg_i(cfg),
    .env_o(env), .done_o(env_done)
  );

  mseg_ram #(.WIDTH(COEFF_W), .DEPTH(COEFF_DEPTH)) u_sin_ram (
    .clk_i, .we_i(we_sin), .waddr_i(waddr), .wdata_i(coefficient_i),
    .raddr_i(raddr), .rdata_o(sin_rd)
  );

  mseg_ram #(.WIDTH(COEFF_W), .DEPTH(COEFF_DEPTH)) u_cos_ram (
    .clk_i, .we_i(we_cos), .waddr_i(waddr), .wdata_i(coefficient_i),
    .raddr_i(raddr), .rdata_o(cos_rd)
  );

  // limits in use
  always_comb begin
    if (cfg.harm == 5'd0) nh = HN_W'(1);
    else if (32'(cfg.harm) > MAX_HARMONICS) nh = HN_W'(MAX_HARMONICS);
    else nh = HN_W'(cfg.harm);
    if (cfg.axes == 4'd0) na = 4'd1;
    else if (32'(cfg.axes) > AXES_CAP) na = 4'(AXES_CAP);
    else na = cfg.axes;
  end

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign t_next     = tick_q + 32'd1;
  assign last_k     = (4'(k_q) + 4'd1 == na);
  assign last_i     = (HN_W'(i_q) + HN_W'(1) == nh);
  assign slot_free  = !out_valid_o || !out_stall_i;

  // coefficient writes
  assign waddr  = CADDR_W'(32'(harmonic_index_i) * MAX_AXES + 32'(axis_index_i));
  assign we_sin = accept && (action_i == ACT_SINE) &&
                  (32'(harmonic_index_i) < MAX_HARMONICS) && (32'(axis_index_i) < MAX_AXES);
  assign we_cos = accept && (action_i == ACT_COSINE) &&
                  (32'(harmonic_index_i) < MAX_HARMONICS) && (32'(axis_index_i) < MAX_AXES);
  assign step_we = accept && (action_i == ACT_STEP) &&
                   (32'(harmonic_index_i) < MAX_HARMONICS);

  // coefficient read and trig index for the harmonic being issued
  assign raddr = CADDR_W'(32'(i_q) * MAX_AXES + 32'(k_q));
  assign tidx  = phase_q[i_q][31 -: TRIG_TABLE_BITS];
  assign sin_c = sv_q ? $signed(sin_rd) : 24'sd0;
  assign cos_c = cv_q ? $signed(cos_rd) : 24'sd0;

  // output scaling and saturation
  assign sh  = prod_q >>> 31;
  assign sat = (sh > 66'sd2147483647) ? 32'sh7fffffff :
               (sh < -66'sd2147483648) ? 32'sh80000000 : sh[31:0];

  // sequencer
  always_comb begin
    state_d   = state_q;
    tick_d    = tick_q;
    run_d     = run_q;
    fin_d     = fin_q;
    i_d       = i_q;
    k_d       = k_q;
    s1_d      = 1'b0;
    env_start = 1'b0;
    phase_adv = 1'b0;
    phase_clr = 1'b0;
    acc_clr   = 1'b0;
    load      = 1'b0;
    val_d     = 32'sd0;
    fin_out_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        k_d = '0;
        i_d = '0;
        if (accept) begin
          case (action_i)
            ACT_TICK: begin
              if (run_q) begin
                if (tick_q == 32'hffffffff) begin
                  run_d   = 1'b0;
                  fin_d   = 1'b1;
                  state_d = ST_ZERO;
                end else begin
                  tick_d    = t_next;
                  phase_adv = 1'b1;
                  if (t_next > cfg.duration) begin
                    run_d   = 1'b0;
                    fin_d   = 1'b1;
                    state_d = ST_ZERO;
                  end else begin
                    state_d = ST_ENV;
                  end
                end
              end
            end
            ACT_STOP: begin
              if (run_q) begin
                run_d   = 1'b0;
                fin_d   = 1'b1;
                state_d = ST_ZERO;
              end
            end
            ACT_RESTART: begin
              tick_d    = 32'd0;
              phase_clr = 1'b1;
              run_d     = 1'b1;
              fin_d     = 1'b0;
              state_d   = ST_ZERO;
            end
            default: ;
          endcase
        end
      end
      ST_ENV: begin
        env_start = !env_done && !s1_q;
        if (env_done) begin
          acc_clr = 1'b1;
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        s1_d = 1'b1;
        if (last_i) begin
          i_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          i_d = i_q + H_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!s1_q && !s2_q) state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_OUT;
      ST_OUT: begin
        if (slot_free) begin
          load  = 1'b1;
          val_d = sat;
          if (last_k) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + K_W'(1);
            acc_clr = 1'b1;
            state_d = ST_MAC;
          end
        end
      end
      ST_ZERO: begin
        if (slot_free) begin
          load      = 1'b1;
          fin_out_d = fin_q;
          if (last_k) state_d = ST_IDLE;
          else        k_d     = k_q + K_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= 32'd0;
      run_q       <= 1'b1;
      fin_q       <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
      out_valid_o <= 1'b0;
      sin_vld_q   <= '0;
      cos_vld_q   <= '0;
    end else begin
      state_q <= state_d;
      tick_q  <= tick_d;
      run_q   <= run_d;
      fin_q   <= fin_d;
      i_q     <= i_d;
      k_q     <= k_d;
      s1_q    <= s1_d;
      s2_q    <= s1_q;
      if (load) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
      if (we_sin) sin_vld_q[waddr] <= 1'b1;
      if (we_cos) cos_vld_q[waddr] <= 1'b1;
    end
  end

  // per-harmonic phase step and accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int h = 0; h < MAX_HARMONICS; h++) begin
        step_q[h]  <= 32'd0;
        phase_q[h] <= 32'd0;
      end
    end else begin
      for (int h = 0; h < MAX_HARMONICS; h++) begin
        if (phase_clr)      phase_q[h] <= 32'd0;
        else if (phase_adv) phase_q[h] <= phase_q[h] + step_q[h];
      end
      if (step_we) step_q[harmonic_index_i[H_W-1:0]] <= phase_step_i;
    end
  end

  // multiply-accumulate datapath
  always_ff @(posedge clk_i) begin
    sv_q    <= sin_vld_q[raddr];
    cv_q    <= cos_vld_q[raddr];
    sin_t_q <= trig_sine(tidx);
    cos_t_q <= trig_sine(tidx + TRIG_TABLE_BITS'(QUARTER));
    ps_q    <= 40'(sin_c) * 40'(sin_t_q);
    pc_q    <= 40'(cos_c) * 40'(cos_t_q);
    if (acc_clr)   acc_q <= '0;
    else if (s2_q) acc_q <= acc_q + ACC_W'(ps_q) + ACC_W'(pc_q);
    prod_q  <= 66'(acc_q) * $signed({49'b0, env});
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      axis_o        <= 3'(k_q);
      kind_o        <= cfg.kind;
      drive_value_o <= val_d;
      last_axis_o   <= last_k;
      finished_o    <= fin_out_d;
    end
  end

endmodule

@@ verif/multisine_excitation_generator_tb.sv @@
// ----------------------------------------------------------------------------
// multisine_excitation_generator_tb
// Drives tick, stop, restart and table-write transactions into the multisine
// generator under several register settings, predicts every axis value with
// an independent fixed-point model and compares each output transaction.
// ----------------------------------------------------------------------------
module multisine_excitation_generator_tb;
  import mseg_pkg::*;

  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam int         DRAIN_CYCLES = 200;
  localparam int         HOLD_CYCLES  = 400;

  typedef struct {
    logic [2:0]         axis;
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic               last;
    logic               fin;
  } drive_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         action_i = '0;
  logic [3:0]         harmonic_index_i = '0;
  logic [2:0]         axis_index_i = '0;
  logic [31:0]        phase_step_i = '0;
  logic signed [23:0] coefficient_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         axis_o;
  logic [1:0]         kind_o;
  logic signed [31:0] drive_value_o;
  logic               last_axis_o;
  logic               finished_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;

  // predictor copy of the registers and the generator state
  logic [31:0]        m_duration;
  logic [30:0]        m_ramp;
  logic [32:0]        m_recip;
  logic [4:0]         m_harm;
  logic [3:0]         m_axes;
  logic [1:0]         m_kind;
  logic [31:0]        m_ticks;
  logic               m_running;
  logic [31:0]        m_step [MAX_HARMONICS];
  logic [31:0]        m_phase [MAX_HARMONICS];
  int                 m_sin_c [MAX_HARMONICS*MAX_AXES];
  int                 m_cos_c [MAX_HARMONICS*MAX_AXES];
  int                 wave [QUARTER+1];

  drive_t             expected_drive [$];
  int                 errors = 0;
  bit                 quiet = 1'b0;
  bit                 hold_req = 1'b0;

  multisine_excitation_generator u_top (.*);

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // quarter wave of the trig table, taylor series in q30
  task automatic build_wave();
    longint unsigned x, x2, term;
    longint          acc;
    for (int i = 0; i <= QUARTER; i++) begin
      x    = (longint'(PI_HALF_Q30) * i) / QUARTER;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) acc -= longint'(term);
        else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      wave[i] = int'((longint'(acc) * 32767 + (64'd1 << 29)) >> 30);
    end
  endtask

  function automatic int sine_at(logic [TRIG_TABLE_BITS-1:0] idx);
    int r;
    r = int'(idx[QW_BITS-1:0]);
    case (idx[TRIG_TABLE_BITS-1 -: 2])
      2'd0:    return wave[r];
      2'd1:    return wave[QUARTER - r];
      2'd2:    return -wave[r];
      default: return -wave[QUARTER - r];
    endcase
  endfunction

  // smoothstep taper in q1.16
  function automatic longint taper(logic [31:0] t);
    logic [31:0]     rmp;
    longint unsigned n, r32, r16, r2, r3;
    longint          env;
    rmp = {1'b0, m_ramp};
    if (rmp > m_duration / 2) rmp = m_duration / 2;
    if (t < rmp) n = t;
    else if (t > m_duration - rmp) n = m_duration - t;
    else return 65536;
    r32 = n * longint'(m_recip);
    if (r32 > (64'd1 << 32)) r32 = 64'd1 << 32;
    r16 = r32 >> 16;
    r2  = (r16 * r16) >> 16;
    r3  = (r2 * r16) >> 16;
    env = 3 * longint'(r2) - 2 * longint'(r3);
    if (env < 0) env = 0;
    if (env > 65536) env = 65536;
    return env;
  endfunction

  function automatic int axes_used();
    int n;
    n = (m_axes == 0) ? 1 : int'(m_axes);
    return (n > AXES_CAP) ? AXES_CAP : n;
  endfunction

  task automatic push_drive(int k, int n, logic signed [31:0] v, logic fin);
    drive_t d;
    d.axis  = k[2:0];
    d.kind  = m_kind;
    d.value = v;
    d.last  = (k + 1 == n);
    d.fin   = fin;
    expected_drive.push_back(d);
  endtask

  task automatic push_zeros(logic fin);
    int n;
    n = axes_used();
    for (int k = 0; k < n; k++) push_drive(k, n, '0, fin);
  endtask

  // expected output transactions of one accepted input transaction
  task automatic predict_drive(logic [2:0] act, logic [3:0] h, logic [2:0] a,
                               logic [31:0] step, logic signed [23:0] coeff);
    int                     n, nh;
    longint                 env, acc, v;
    logic [TRIG_TABLE_BITS-1:0] idx;
    case (act)
      ACT_TICK: begin
        if (!m_running) return;
        if (m_ticks == 32'hFFFF_FFFF) begin
          m_running = 1'b0;
          push_zeros(1'b1);
          return;
        end
        m_ticks++;
        for (int i = 0; i < MAX_HARMONICS; i++) m_phase[i] += m_step[i];
        if (m_ticks > m_duration) begin
          m_running = 1'b0;
          push_zeros(1'b1);
          return;
        end
        env = taper(m_ticks);
        n   = axes_used();
        nh  = (m_harm == 0) ? 1 : int'(m_harm);
        if (nh > MAX_HARMONICS) nh = MAX_HARMONICS;
        for (int k = 0; k < n; k++) begin
          acc = 0;
          for (int i = 0; i < nh; i++) begin
            idx = m_phase[i][31 -: TRIG_TABLE_BITS];
            acc += longint'(m_cos_c[i*MAX_AXES+k]) * sine_at(idx + QUARTER)
                 + longint'(m_sin_c[i*MAX_AXES+k]) * sine_at(idx);
          end
          v = (acc * env) >>> 31;
          if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
          if (v < -64'sh8000_0000) v = -64'sh8000_0000;
          push_drive(k, n, v[31:0], 1'b0);
        end
      end
      ACT_STOP: begin
        if (!m_running) return;
        m_running = 1'b0;
        push_zeros(1'b1);
      end
      ACT_RESTART: begin
        m_ticks   = '0;
        m_running = 1'b1;
        for (int i = 0; i < MAX_HARMONICS; i++) m_phase[i] = '0;
        push_zeros(1'b0);
      end
      ACT_STEP: m_step[h] = step;
      ACT_SINE: m_sin_c[h*MAX_AXES+a] = int'(coeff);
      ACT_COSINE: m_cos_c[h*MAX_AXES+a] = int'(coeff);
      default: ;
    endcase
  endtask

  // send one input transaction, called at a rising edge
  task automatic send(logic [2:0] act, logic [3:0] h = '0, logic [2:0] a = '0,
                      logic [31:0] step = '0, logic signed [23:0] coeff = '0);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= act;
    harmonic_index_i <= h;
    axis_index_i     <= a;
    phase_step_i     <= step;
    coefficient_i    <= coeff;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
    predict_drive(act, h, a, step, coeff);
  endtask

  task automatic send_random_write();
    logic [2:0] act;
    act = ACT_STEP + 3'($urandom_range(0, 2));
    send(act, 4'($urandom), 3'($urandom), $urandom, 24'($urandom));
  endtask

  // wait until every expected transaction is out and the sequencer is quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // apb register write, setup then access
  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= PADDR_W'({idx, 3'b000});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DURATION: m_duration = val[31:0];
      REG_RAMP:     m_ramp     = val[30:0];
      REG_RECIP:    m_recip    = val[32:0];
      REG_HARM:     m_harm     = val[4:0];
      REG_AXES:     m_axes     = val[3:0];
      REG_KIND:     m_kind     = val[1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [31:0] dur, logic [30:0] rmp, logic [32:0] rcp,
                            logic [4:0] harm, logic [3:0] axes, logic [1:0] kind);
    drain();
    reg_write(REG_DURATION, 64'(dur));
    reg_write(REG_RAMP, 64'(rmp));
    reg_write(REG_RECIP, 64'(rcp));
    reg_write(REG_HARM, 64'(harm));
    reg_write(REG_AXES, 64'(axes));
    reg_write(REG_KIND, 64'(kind));
  endtask

  // output side: random stall bursts and one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // compare each output transaction with the oldest expectation
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_drive.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction axis %0d value %0d",
                 $realtime, axis_o, drive_value_o);
      end else begin
        drive_t e;
        e = expected_drive.pop_front();
        if (axis_o !== e.axis) begin
          errors++;
          $display("%0t: axis exp %0d got %0d", $realtime, e.axis, axis_o);
        end
        if (kind_o !== e.kind) begin
          errors++;
          $display("%0t: kind exp %0d got %0d", $realtime, e.kind, kind_o);
        end
        if (drive_value_o !== e.value) begin
          errors++;
          $display("%0t: drive_value exp %0d got %0d", $realtime, e.value,
                   drive_value_o);
        end
        if (last_axis_o !== e.last) begin
          errors++;
          $display("%0t: last_axis exp %0b got %0b", $realtime, e.last, last_axis_o);
        end
        if (finished_o !== e.fin) begin
          errors++;
          $display("%0t: finished exp %0b got %0b", $realtime, e.fin, finished_o);
        end
      end
    end
  end

  // table extremes, every action, halted and spare actions
  task automatic test_actions();
    send(ACT_STEP, 4'd0, 3'd0, 32'h0100_0000);
    send(ACT_STEP, 4'd15, 3'd0, 32'hFFFF_FFFF);
    send(ACT_SINE, 4'd0, 3'd0, '0, 24'sh7FFFFF);
    send(ACT_COSINE, 4'd0, 3'd0, '0, -24'sh800000);
    send(ACT_SINE, 4'd15, 3'd7, '0, -24'sd1);
    send(ACT_COSINE, 4'd15, 3'd7, 32'hFFFF_FFFF, 24'sh7FFFFF);
    repeat (3) send(ACT_TICK);
    send(ACT_STOP);
    send(ACT_TICK);
    send(ACT_STOP);
    send(ACT_RESTART);
    send(ACT_SPARE_LO, 4'hF, 3'h7, 32'hFFFF_FFFF, -24'sd1);
    send(ACT_SPARE_HI);
    send(ACT_TICK);
  endtask

  // extreme register settings, taper end and clamping
  task automatic test_register_extremes();
    set_config(32'd20, 31'd15, 33'h1111_1111, 5'd31, 4'd15, 2'd3);
    send(ACT_RESTART);
    for (int i = 0; i < 16; i++) begin
      send(ACT_STEP, 4'(i), 3'd0, $urandom);
      send(ACT_COSINE, 4'(i), 3'(i), '0, 24'($urandom));
    end
    repeat (22) send(ACT_TICK);
    set_config(32'hFFFF_FFFF, 31'h7FFF_FFFF, 33'h1_FFFF_FFFF, 5'd0, 4'd0, 2'd2);
    send(ACT_RESTART);
    repeat (4) send(ACT_TICK);
    set_config(32'd1, 31'd1, 33'd0, 5'd16, 4'd8, 2'd1);
    send(ACT_RESTART);
    repeat (3) send(ACT_TICK);
  endtask

  // output held off while ticks keep coming, then a sender pause
  task automatic test_backpressure();
    set_config(32'd200, 31'd30, 33'(64'h1_0000_0000 / 30), 5'd4, 4'd6, 2'd0);
    send(ACT_RESTART);
    hold_req = 1'b1;
    repeat (20) send(ACT_TICK);
    in_valid_i <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk_i);
    repeat (5) send(ACT_TICK);
  endtask

  // random settings, coefficient loads and tick sequences
  task automatic test_random(int items);
    int          sent;
    logic [31:0] dur;
    logic [30:0] rmp;
    int          pick;
    sent = 0;
    while (sent < items) begin
      dur = $urandom_range(8, 60);
      rmp = 31'($urandom_range(1, dur));
      set_config(dur, rmp, 33'(64'h1_0000_0000 / rmp), 5'($urandom_range(0, 20)),
                 4'($urandom_range(0, 9)), 2'($urandom));
      if (items - sent < 40) quiet = 1'b1;
      send(ACT_RESTART);
      repeat ($urandom_range(4, 12)) send_random_write();
      repeat ($urandom_range(20, 40)) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) send(ACT_TICK);
        else if (pick < 85) send(ACT_STOP);
        else if (pick < 90) send(ACT_RESTART);
        else if (pick < 98) send_random_write();
        else send(3'($urandom), 4'($urandom), 3'($urandom), $urandom, 24'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    build_wave();
    m_duration = 32'd1000;
    m_ramp     = 31'd100;
    m_recip    = 33'd42949673;
    m_harm     = 5'd1;
    m_axes     = 4'd1;
    m_kind     = 2'd0;
    m_ticks    = '0;
    m_running  = 1'b1;
    for (int i = 0; i < MAX_HARMONICS; i++) begin
      m_step[i]  = '0;
      m_phase[i] = '0;
    end
    for (int i = 0; i < MAX_HARMONICS*MAX_AXES; i++) begin
      m_sin_c[i] = 0;
      m_cos_c[i] = 0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_actions();
    test_register_extremes();
    test_backpressure();
    test_random(120);
    drain();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
